[hdl/ifa_pkg.sv]
package ifa_pkg;

    localparam int BIN_W           = 64;
    localparam int NUM_DIGITS      = 20;
    localparam int BCD_W           = 4 * NUM_DIGITS;
    localparam int STEP_W          = $clog2(BIN_W);
    localparam int ND_W            = $clog2(NUM_DIGITS + 1);
    localparam int DIG_IDX_W       = $clog2(NUM_DIGITS);
    localparam int MAX_CHARS       = 64;
    localparam int CNT_W           = $clog2(MAX_CHARS + 1);
    localparam int WIDTH_W         = 7;
    localparam int PREC_W          = 6;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;

    typedef logic [NUM_DIGITS-1:0][3:0] t_digits;

    typedef struct packed {
        t_digits             dig;
        logic [ND_W-1:0]     nd;
        logic                neg;
        logic                upc;
        logic                left;
        logic                zpad;
        logic                prec_on;
        logic [PREC_W-1:0]   prec;
        logic [WIDTH_W-1:0]  width;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_xfer;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upc);
        logic [7:0] base;
        if (d < 4'd10) begin
            digit_char = CH_ZERO + {4'b0, d};
        end else begin
            base = upc ? CH_UA : CH_LA;
            digit_char = base + {4'b0, d} - 8'd10;
        end
    endfunction

endpackage

[hdl/ifa_front.sv]
module ifa_front import ifa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [BIN_W-1:0]    i_value,
    input  logic                i_is_signed,
    input  logic                i_hex_base,
    input  logic                i_upper_case,
    input  logic [WIDTH_W-1:0]  i_field_width,
    input  logic [PREC_W-1:0]   i_min_digits,
    input  logic                i_precision_on,
    input  logic                i_left_align,
    input  logic                i_zero_pad,
    input  logic                i_q_full,
    output t_xfer               o_push
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CONV = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [BIN_W-1:0]    r_bin;
    logic [BCD_W-1:0]    r_bcd;
    logic [STEP_W-1:0]   r_step;
    logic                r_neg, r_upc, r_left, r_zpad, r_prec_on;
    logic [PREC_W-1:0]   r_prec;
    logic [WIDTH_W-1:0]  r_width;

    logic                accept;
    logic                neg_in;
    logic [BIN_W-1:0]    mag_in;
    logic [BCD_W-1:0]    bcd_adj;

    function automatic logic [ND_W-1:0] count_digits(input logic [BCD_W-1:0] b);
        logic [ND_W-1:0] nd;
        nd = ND_W'(1);
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (b[4*i +: 4] != 4'd0) nd = ND_W'(i + 1);
        end
        return nd;
    endfunction

    assign accept = start && (r_state == F_IDLE);
    assign busy   = (r_state != F_IDLE);
    assign neg_in = !i_hex_base && i_is_signed && i_value[BIN_W-1];
    assign mag_in = neg_in ? (BIN_W'(0) - i_value) : i_value;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? (r_bcd[4*i +: 4] + 4'd3)
                                                          : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept) n_state = i_hex_base ? F_PUSH : F_CONV;
            end
            F_CONV: begin
                if (r_step == STEP_W'(BIN_W - 1)) n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_q_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (accept) begin
            r_bin     <= mag_in;
            r_bcd     <= i_hex_base ? BCD_W'(mag_in) : '0;
            r_step    <= '0;
            r_neg     <= neg_in;
            r_upc     <= i_upper_case;
            r_left    <= i_left_align;
            r_zpad    <= i_zero_pad;
            r_prec_on <= i_precision_on;
            r_prec    <= i_min_digits;
            r_width   <= (i_field_width > WIDTH_W'(MAX_CHARS)) ? WIDTH_W'(MAX_CHARS)
                                                               : i_field_width;
        end else if (r_state == F_CONV) begin
            {r_bcd, r_bin} <= {bcd_adj[BCD_W-2:0], r_bin, 1'b0};
            r_step         <= r_step + STEP_W'(1);
        end
    end

    always_comb begin
        o_push.valid        = (r_state == F_PUSH);
        o_push.desc.dig     = r_bcd;
        o_push.desc.nd      = count_digits(r_bcd);
        o_push.desc.neg     = r_neg;
        o_push.desc.upc     = r_upc;
        o_push.desc.left    = r_left;
        o_push.desc.zpad    = r_zpad;
        o_push.desc.prec_on = r_prec_on;
        o_push.desc.prec    = r_prec;
        o_push.desc.width   = r_width;
    end

endmodule

[hdl/ifa_queue.sv]
module ifa_queue import ifa_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_xfer i_push,
    output logic  o_full,
    input  logic  i_pop,
    output t_xfer o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_desc          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           push, pop;

    assign o_full = (r_count == CW'(DEPTH));
    assign push   = i_push.valid && !o_full;
    assign pop    = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.desc  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.desc;
        end
    end

endmodule

[hdl/ifa_back.sv]
module ifa_back import ifa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_xfer       i_head,
    output logic        o_pop,
    output logic        o_valid,
    output logic [7:0]  o_out_char,
    output logic        o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PICK = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam logic [2:0] PH_LPAD = 3'd0;
    localparam logic [2:0] PH_SIGN = 3'd1;
    localparam logic [2:0] PH_ZERO = 3'd2;
    localparam logic [2:0] PH_DIG  = 3'd3;
    localparam logic [2:0] PH_RPAD = 3'd4;

    typedef struct packed {
        logic [2:0]       ph;
        logic [CNT_W-1:0] cnt;
    } t_pick;

    logic [1:0]          r_state, n_state;
    logic [2:0]          r_phase;
    logic [CNT_W-1:0]    r_cnt, r_remain;
    t_digits             r_dig;
    logic [ND_W-1:0]     r_nd;
    logic                r_neg, r_upc;
    logic [CNT_W-1:0]    r_c_lpad, r_c_zero, r_c_rpad;

    t_desc               h;
    logic [PREC_W-1:0]   ndig;
    logic [CNT_W-1:0]    body, total, pad;
    logic [CNT_W-1:0]    c_lpad, c_zero, c_rpad;
    logic [DIG_IDX_W-1:0] idx;
    t_pick               first_pick, next_pick;

    function automatic t_pick pick_from(
        input logic [2:0]       ph,
        input logic [CNT_W-1:0] lpad,
        input logic             neg,
        input logic [CNT_W-1:0] zero,
        input logic [ND_W-1:0]  nd,
        input logic [CNT_W-1:0] rpad
    );
        t_pick p;
        p.ph  = PH_RPAD;
        p.cnt = rpad;
        if (ph <= PH_DIG) begin
            p.ph  = PH_DIG;
            p.cnt = CNT_W'(nd);
        end
        if (ph <= PH_ZERO && zero != '0) begin
            p.ph  = PH_ZERO;
            p.cnt = zero;
        end
        if (ph <= PH_SIGN && neg) begin
            p.ph  = PH_SIGN;
            p.cnt = CNT_W'(1);
        end
        if (ph == PH_LPAD && lpad != '0) begin
            p.ph  = PH_LPAD;
            p.cnt = lpad;
        end
        return p;
    endfunction

    assign h = i_head.desc;

    always_comb begin
        ndig   = (h.prec_on && (h.prec > PREC_W'(h.nd))) ? h.prec : PREC_W'(h.nd);
        body   = CNT_W'(ndig) + CNT_W'(h.neg);
        total  = (CNT_W'(h.width) > body) ? CNT_W'(h.width) : body;
        pad    = total - body;
        c_lpad = (!h.left && !h.zpad) ? pad : '0;
        c_zero = CNT_W'(ndig) - CNT_W'(h.nd) + ((!h.left && h.zpad) ? pad : '0);
        c_rpad = h.left ? pad : '0;
    end

    assign first_pick = pick_from(PH_LPAD, r_c_lpad, r_neg, r_c_zero, r_nd, r_c_rpad);
    assign next_pick  = pick_from(r_phase + 3'd1, r_c_lpad, r_neg, r_c_zero, r_nd, r_c_rpad);

    assign o_pop = (r_state == S_IDLE) && i_head.valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) n_state = S_PICK;
            end
            S_PICK: n_state = S_EMIT;
            S_EMIT: begin
                if (r_remain == CNT_W'(1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (o_pop) begin
            r_dig    <= h.dig;
            r_nd     <= h.nd;
            r_neg    <= h.neg;
            r_upc    <= h.upc;
            r_c_lpad <= c_lpad;
            r_c_zero <= c_zero;
            r_c_rpad <= c_rpad;
            r_remain <= total;
        end
        if (r_state == S_PICK) begin
            r_phase <= first_pick.ph;
            r_cnt   <= first_pick.cnt;
        end else if (r_state == S_EMIT) begin
            r_remain <= r_remain - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_phase <= next_pick.ph;
                r_cnt   <= next_pick.cnt;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    assign idx = r_cnt[DIG_IDX_W-1:0] - DIG_IDX_W'(1);

    always_comb begin
        unique case (r_phase)
            PH_LPAD: o_out_char = CH_SPACE;
            PH_SIGN: o_out_char = CH_MINUS;
            PH_ZERO: o_out_char = CH_ZERO;
            PH_DIG:  o_out_char = digit_char(r_dig[idx], r_upc);
            PH_RPAD: o_out_char = CH_SPACE;
            default: o_out_char = CH_SPACE;
        endcase
    end

    assign o_valid = (r_state == S_EMIT);
    assign o_last  = o_valid && (r_remain == CNT_W'(1));

`ifndef SYNTH
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("character strobe right after last character");

    a_sign_only_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_phase == PH_SIGN) |-> r_neg)
        else $error("minus sign emitted for non-negative number");

    a_last_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> ((r_phase == PH_DIG) && (r_cnt == CNT_W'(1)))
                              || (r_phase == PH_RPAD))
        else $error("last character is neither final digit nor right padding");
`endif

endmodule

[hdl/integer_to_ascii_formatter_unit.sv]
// Integer to ASCII formatter: turns one 64-bit integer with printf-style options
// into its text, one character per result.
// Input: a transaction is taken at a rising edge with start high and busy low;
// value and format options are sampled on that edge.
// Output: each character is shown on o_out_char for exactly one cycle with
// o_valid high; o_last marks the final character. The receiver cannot stall:
// every strobed character is taken at the edge that ends its cycle.
// Decimal numbers go through a 64-step binary-to-BCD converter before they
// are queued; hex numbers skip the converter and are queued directly. The
// character sequencer then takes each descriptor, picks its first phase and
// emits its characters. The converter and the sequencer run independently,
// joined by a small descriptor queue, so a new number can be converted while
// the sequencer emits 1 to 64 characters for an earlier one; the sustained
// rate is set by the slower of the two.
// busy is high while the converter holds a number, including while the queue
// is full.
// Reset empties the queue, stops any output in progress and leaves busy low.
module integer_to_ascii_formatter_unit import ifa_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [BIN_W-1:0]    i_value,
    input  logic                i_is_signed,
    input  logic                i_hex_base,
    input  logic                i_upper_case,
    input  logic [WIDTH_W-1:0]  i_field_width,
    input  logic [PREC_W-1:0]   i_min_digits,
    input  logic                i_precision_on,
    input  logic                i_left_align,
    input  logic                i_zero_pad,
    output logic                o_valid,
    output logic [7:0]          o_out_char,
    output logic                o_last
);

    t_xfer push, head;
    logic  q_full, pop;

    ifa_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_is_signed    (i_is_signed),
        .i_hex_base     (i_hex_base),
        .i_upper_case   (i_upper_case),
        .i_field_width  (i_field_width),
        .i_min_digits   (i_min_digits),
        .i_precision_on (i_precision_on),
        .i_left_align   (i_left_align),
        .i_zero_pad     (i_zero_pad),
        .i_q_full       (q_full),
        .o_push         (push)
    );

    ifa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head)
    );

    ifa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

endmodule
